// ===== sv/carpm_pkg.sv =====
// Shared types, constants and microcode program of the cascaded attitude/rate controller.
`timescale 1ns / 1ps

package carpm_pkg;

	// Storage width of the error integrals
	localparam int INTEGRAL_WIDTH_DFLT = 40;

	// Idle throttle handling and motor range
	localparam logic [11:0] IDLE_THROTTLE = 12'd1100;
	localparam logic [11:0] IDLE_MOTOR    = 12'd1000;
	localparam logic [11:0] MOTOR_MAX     = 12'd4095;

	// Register indexes
	localparam logic [2:0] REG_OUTER_P    = 3'd0;
	localparam logic [2:0] REG_OUTER_I    = 3'd1;
	localparam logic [2:0] REG_INNER_P    = 3'd2;
	localparam logic [2:0] REG_INNER_I    = 3'd3;
	localparam logic [2:0] REG_TARGET     = 3'd4;
	localparam logic [2:0] REG_ANG_LIMIT  = 3'd5;
	localparam logic [2:0] REG_RATE_LIMIT = 3'd6;
	localparam logic [2:0] REG_OUT_LIMITS = 3'd7;

	// Register reset values
	localparam logic [47:0] OUTER_P_RST    = 48'h0000_1800_1800;
	localparam logic [47:0] OUTER_I_RST    = 48'h0000_0000_0000;
	localparam logic [47:0] INNER_P_RST    = 48'h0000_1000_1000;
	localparam logic [47:0] INNER_I_RST    = 48'h0000_0000_0000;
	localparam logic [47:0] TARGET_RST     = 48'h1680_0000_0000;
	localparam logic [14:0] ANG_LIMIT_RST  = 15'd3200;
	localparam logic [14:0] RATE_LIMIT_RST = 15'd640;
	localparam logic [31:0] OUT_LIMITS_RST = 32'h00C8_0640;

	// Axis codes
	localparam logic [1:0] AXIS_ROLL  = 2'd0;
	localparam logic [1:0] AXIS_PITCH = 2'd1;
	localparam logic [1:0] AXIS_YAW   = 2'd2;
	localparam logic [1:0] AXIS_LAST  = AXIS_YAW;

	// Control loop codes
	localparam logic STAGE_OUTER = 1'b0;
	localparam logic STAGE_INNER = 1'b1;

	// Program addresses
	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_ANG_ERR  = 4'd0;
	localparam logic [STEP_W-1:0] STEP_O_EDT    = 4'd1;
	localparam logic [STEP_W-1:0] STEP_O_IADD   = 4'd2;
	localparam logic [STEP_W-1:0] STEP_O_IWR    = 4'd3;
	localparam logic [STEP_W-1:0] STEP_O_IKI    = 4'd4;
	localparam logic [STEP_W-1:0] STEP_O_SUM    = 4'd5;
	localparam logic [STEP_W-1:0] STEP_CMD      = 4'd6;
	localparam logic [STEP_W-1:0] STEP_RATE_ERR = 4'd7;
	localparam logic [STEP_W-1:0] STEP_I_EDT    = 4'd8;
	localparam logic [STEP_W-1:0] STEP_I_IADD   = 4'd9;
	localparam logic [STEP_W-1:0] STEP_I_IWR    = 4'd10;
	localparam logic [STEP_W-1:0] STEP_I_IKI    = 4'd11;
	localparam logic [STEP_W-1:0] STEP_I_SUM    = 4'd12;
	localparam logic [STEP_W-1:0] STEP_CORR     = 4'd13;
	localparam logic [STEP_W-1:0] STEP_DONE     = 4'd14;

	// Multiplier operand pairs
	typedef enum logic [1:0] {
		MUL_NONE,
		MUL_E_DT,
		MUL_E_KP,
		MUL_I_KI
	} mul_sel_t;

	// Accumulator operations
	typedef enum logic [1:0] {
		ACC_HOLD,
		ACC_INT_ADD,
		ACC_LOAD_P,
		ACC_ADD_PSH
	} acc_op_t;

	// Error register operations
	typedef enum logic [1:0] {
		E_HOLD,
		E_ANGLE,
		E_RATE
	} e_op_t;

	// Loop result operations
	typedef enum logic [1:0] {
		FIN_NONE,
		FIN_CMD,
		FIN_CORR
	} fin_op_t;

	// Sequencing
	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_AXIS,
		JMP_DONE
	} jmp_t;

	typedef struct packed {
		logic              stage;
		mul_sel_t          mul;
		acc_op_t           acc;
		logic              int_wr;
		e_op_t             e_op;
		fin_op_t           fin;
		jmp_t              jmp;
		logic [STEP_W-1:0] target;
	} ucode_t;

	localparam ucode_t UC_NOP = '{
		stage:  STAGE_OUTER,
		mul:    MUL_NONE,
		acc:    ACC_HOLD,
		int_wr: 1'b0,
		e_op:   E_HOLD,
		fin:    FIN_NONE,
		jmp:    JMP_NEXT,
		target: STEP_ANG_ERR
	};

	// Control store: one word per program step
	function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] pc);
		ucode_t uc;
		uc = UC_NOP;
		case (pc)
			STEP_ANG_ERR: uc.e_op = E_ANGLE;
			STEP_O_EDT, STEP_I_EDT: uc.mul = MUL_E_DT;
			STEP_O_IADD, STEP_I_IADD: begin
				uc.acc = ACC_INT_ADD;
				uc.mul = MUL_E_KP;
			end
			STEP_O_IWR, STEP_I_IWR: begin
				uc.int_wr = 1'b1;
				uc.acc    = ACC_LOAD_P;
			end
			STEP_O_IKI, STEP_I_IKI: uc.mul = MUL_I_KI;
			STEP_O_SUM, STEP_I_SUM: uc.acc = ACC_ADD_PSH;
			STEP_CMD: uc.fin = FIN_CMD;
			STEP_RATE_ERR: uc.e_op = E_RATE;
			STEP_CORR: begin
				uc.fin    = FIN_CORR;
				uc.jmp    = JMP_AXIS;
				uc.target = STEP_ANG_ERR;
			end
			STEP_DONE: uc.jmp = JMP_DONE;
			default: uc.jmp = JMP_DONE;
		endcase
		uc.stage = (pc >= STEP_RATE_ERR) ? STAGE_INNER : STAGE_OUTER;
		return uc;
	endfunction

endpackage

// ===== sv/cascaded_attitude_rate_pi_mixer.sv =====
// Cascaded attitude/rate PI controller with X motor mixer, run by a microcoded sequencer.
// Each input word runs 14 program steps per axis on one shared 32x17 multiplier, three
// axes, then one mixing step into the output register, which waits while the output is
// stalled; no new input word is accepted until then.
// A new input word is taken while the previous result still waits in the output register.
// Reset (arst_n low) clears the sequencer, the output valid, all integrals to zero and
// loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module cascaded_attitude_rate_pi_mixer #(
	parameter int INTEGRAL_WIDTH = carpm_pkg::INTEGRAL_WIDTH_DFLT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// roll_angle, pitch_angle, yaw_angle, roll_rate, pitch_rate, yaw_rate (16 each),
	// throttle (12), elapsed_time (16), 4 bits zero
	input  logic                        s_axis_tvalid,
	output logic                        s_axis_tready,
	input  logic [127:0]                s_axis_tdata,
	// motor_a, motor_b, motor_c, motor_d (12 each)
	output logic                        m_axis_tvalid,
	input  logic                        m_axis_tready,
	output logic [47:0]                 m_axis_tdata,
	// idle
	output logic [0:0]                  m_axis_tuser,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [5:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready
);

	// Configuration registers
	logic [47:0] outer_p_q, outer_i_q, inner_p_q, inner_i_q, target_q;
	logic [14:0] ang_lim_q, rate_lim_q;
	logic [31:0] out_lim_q;

	// Sequencer
	logic                           busy_q;
	logic [carpm_pkg::STEP_W-1:0]   pc_q;
	logic [1:0]                     axis_q;
	carpm_pkg::ucode_t              uc;

	// Datapath
	logic [127:0]                   in_q;
	logic signed [17:0]             e_q;
	logic signed [35:0]             acc_q;
	logic signed [48:0]             p_q;
	logic signed [16:0]             c_q;
	logic signed [16:0]             corr_q [3];
	logic signed [INTEGRAL_WIDTH-1:0] ang_int_q [3];
	logic signed [INTEGRAL_WIDTH-1:0] rate_int_q [3];

	// Output register
	logic        m_tvalid_q;
	logic [47:0] m_data_q;
	logic        m_user_q;

	logic in_acc, cfg_wr, done_go;
	logic [15:0] dt;
	logic [11:0] thr;
	logic signed [15:0] ang_sel, rate_sel, tgt_sel, kp_sel, ki_sel;
	logic [47:0] kp_reg, ki_reg;
	logic signed [INTEGRAL_WIDTH-1:0] int_rd_w;
	logic signed [31:0] int_rd, int_clamped;
	logic [14:0] int_lim;
	logic signed [31:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [48:0] mul_prod;
	logic signed [16:0] cmd_next, corr_next;
	logic signed [18:0] mot_a, mot_b, mot_c, mot_d;
	logic [47:0] mix_data;
	logic        mix_idle;

	function automatic logic signed [15:0] field16(input logic [47:0] r, input logic [1:0] ax);
		logic signed [15:0] f;
		case (ax)
			carpm_pkg::AXIS_ROLL:  f = r[15:0];
			carpm_pkg::AXIS_PITCH: f = r[31:16];
			default:               f = r[47:32];
		endcase
		return f;
	endfunction

	function automatic logic [11:0] sat_motor(input logic signed [18:0] x);
		logic [11:0] m;
		if (x < 19'sd0)
			m = '0;
		else if (x > signed'({7'd0, carpm_pkg::MOTOR_MAX}))
			m = carpm_pkg::MOTOR_MAX;
		else
			m = x[11:0];
		return m;
	endfunction

	// Decode the current program step
	assign uc = carpm_pkg::ucode_rom(pc_q);

	assign s_axis_tready = !busy_q;
	assign in_acc = s_axis_tvalid && s_axis_tready;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign done_go = busy_q && uc.jmp == carpm_pkg::JMP_DONE && (!m_tvalid_q || m_axis_tready);

	// Pick input fields, gains and stored integral for the current axis and loop
	assign dt  = in_q[123:108];
	assign thr = in_q[107:96];

	always_comb begin
		case (axis_q)
			carpm_pkg::AXIS_ROLL: begin
				ang_sel  = in_q[15:0];
				rate_sel = in_q[63:48];
			end
			carpm_pkg::AXIS_PITCH: begin
				ang_sel  = in_q[31:16];
				rate_sel = in_q[79:64];
			end
			default: begin
				ang_sel  = in_q[47:32];
				rate_sel = in_q[95:80];
			end
		endcase
	end

	assign kp_reg  = (uc.stage == carpm_pkg::STAGE_INNER) ? inner_p_q : outer_p_q;
	assign ki_reg  = (uc.stage == carpm_pkg::STAGE_INNER) ? inner_i_q : outer_i_q;
	assign kp_sel  = field16(kp_reg, axis_q);
	assign ki_sel  = field16(ki_reg, axis_q);
	assign tgt_sel = field16(target_q, axis_q);
	assign int_lim = (uc.stage == carpm_pkg::STAGE_INNER) ? rate_lim_q : ang_lim_q;

	always_comb begin
		case ({uc.stage, axis_q})
			{carpm_pkg::STAGE_OUTER, carpm_pkg::AXIS_ROLL}:  int_rd_w = ang_int_q[0];
			{carpm_pkg::STAGE_OUTER, carpm_pkg::AXIS_PITCH}: int_rd_w = ang_int_q[1];
			{carpm_pkg::STAGE_OUTER, carpm_pkg::AXIS_YAW}:   int_rd_w = ang_int_q[2];
			{carpm_pkg::STAGE_INNER, carpm_pkg::AXIS_ROLL}:  int_rd_w = rate_int_q[0];
			{carpm_pkg::STAGE_INNER, carpm_pkg::AXIS_PITCH}: int_rd_w = rate_int_q[1];
			default:                                          int_rd_w = rate_int_q[2];
		endcase
	end

	// Integrals never leave the clamp range, so the low 32 bits carry the value
	assign int_rd = int_rd_w[31:0];

	// Shared multiplier
	always_comb begin
		case (uc.mul)
			carpm_pkg::MUL_E_DT: begin
				mul_a = 32'(e_q);
				mul_b = signed'({1'b0, dt});
			end
			carpm_pkg::MUL_E_KP: begin
				mul_a = 32'(e_q);
				mul_b = 17'(kp_sel);
			end
			carpm_pkg::MUL_I_KI: begin
				mul_a = int_rd;
				mul_b = 17'(ki_sel);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_prod = mul_a * mul_b;

	// Clamp the new integral symmetrically
	always_comb begin
		logic signed [35:0] lim36;
		lim36 = signed'({5'd0, int_lim, 16'd0});
		if (acc_q > lim36)
			int_clamped = lim36[31:0];
		else if (acc_q < -lim36)
			int_clamped = 32'(-lim36);
		else
			int_clamped = acc_q[31:0];
	end

	// Round the rate command half up to 1/32 deg/s, then clamp
	always_comb begin
		logic signed [36:0] rnd_sum;
		logic signed [24:0] cmd_raw, lim25;
		rnd_sum = 37'(acc_q) + 37'sd2048;
		cmd_raw = rnd_sum[36:12];
		lim25   = signed'({9'd0, out_lim_q[15:0]});
		if (cmd_raw > lim25)
			cmd_next = lim25[16:0];
		else if (cmd_raw < -lim25)
			cmd_next = 17'(-lim25);
		else
			cmd_next = cmd_raw[16:0];
	end

	// Truncate the correction toward zero to whole counts, then clamp
	always_comb begin
		logic signed [36:0] trn_sum;
		logic signed [19:0] corr_raw, lim20;
		trn_sum  = 37'(acc_q) + (acc_q[35] ? 37'sd131071 : 37'sd0);
		corr_raw = trn_sum[36:17];
		lim20    = signed'({4'd0, out_lim_q[31:16]});
		if (corr_raw > lim20)
			corr_next = lim20[16:0];
		else if (corr_raw < -lim20)
			corr_next = 17'(-lim20);
		else
			corr_next = corr_raw[16:0];
	end

	// X mixer with idle override
	always_comb begin
		logic signed [18:0] thr19;
		thr19 = signed'({7'd0, thr});
		mot_a = thr19 + 19'(corr_q[1]) + 19'(corr_q[2]);
		mot_b = thr19 + 19'(corr_q[0]) - 19'(corr_q[2]);
		mot_c = thr19 - 19'(corr_q[1]) + 19'(corr_q[2]);
		mot_d = thr19 - 19'(corr_q[0]) - 19'(corr_q[2]);
		mix_idle = thr < carpm_pkg::IDLE_THROTTLE;
		if (mix_idle)
			mix_data = {4{carpm_pkg::IDLE_MOTOR}};
		else
			mix_data = {sat_motor(mot_d), sat_motor(mot_c), sat_motor(mot_b), sat_motor(mot_a)};
	end

	// Control state, integrals and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			pc_q       <= carpm_pkg::STEP_ANG_ERR;
			axis_q     <= carpm_pkg::AXIS_ROLL;
			m_tvalid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				ang_int_q[i]  <= '0;
				rate_int_q[i] <= '0;
			end
			outer_p_q  <= carpm_pkg::OUTER_P_RST;
			outer_i_q  <= carpm_pkg::OUTER_I_RST;
			inner_p_q  <= carpm_pkg::INNER_P_RST;
			inner_i_q  <= carpm_pkg::INNER_I_RST;
			target_q   <= carpm_pkg::TARGET_RST;
			ang_lim_q  <= carpm_pkg::ANG_LIMIT_RST;
			rate_lim_q <= carpm_pkg::RATE_LIMIT_RST;
			out_lim_q  <= carpm_pkg::OUT_LIMITS_RST;
		end else begin
			// Register writes
			if (cfg_wr) begin
				case (paddr[5:3])
					carpm_pkg::REG_OUTER_P:    outer_p_q  <= pwdata[47:0];
					carpm_pkg::REG_OUTER_I:    outer_i_q  <= pwdata[47:0];
					carpm_pkg::REG_INNER_P:    inner_p_q  <= pwdata[47:0];
					carpm_pkg::REG_INNER_I:    inner_i_q  <= pwdata[47:0];
					carpm_pkg::REG_TARGET:     target_q   <= pwdata[47:0];
					carpm_pkg::REG_ANG_LIMIT:  ang_lim_q  <= pwdata[14:0];
					carpm_pkg::REG_RATE_LIMIT: rate_lim_q <= pwdata[14:0];
					default:                   out_lim_q  <= pwdata[31:0];
				endcase
			end

			// Store the clamped integral
			if (busy_q && uc.int_wr) begin
				case ({uc.stage, axis_q})
					{carpm_pkg::STAGE_OUTER, carpm_pkg::AXIS_ROLL}:
						ang_int_q[0] <= INTEGRAL_WIDTH'(int_clamped);
					{carpm_pkg::STAGE_OUTER, carpm_pkg::AXIS_PITCH}:
						ang_int_q[1] <= INTEGRAL_WIDTH'(int_clamped);
					{carpm_pkg::STAGE_OUTER, carpm_pkg::AXIS_YAW}:
						ang_int_q[2] <= INTEGRAL_WIDTH'(int_clamped);
					{carpm_pkg::STAGE_INNER, carpm_pkg::AXIS_ROLL}:
						rate_int_q[0] <= INTEGRAL_WIDTH'(int_clamped);
					{carpm_pkg::STAGE_INNER, carpm_pkg::AXIS_PITCH}:
						rate_int_q[1] <= INTEGRAL_WIDTH'(int_clamped);
					default:
						rate_int_q[2] <= INTEGRAL_WIDTH'(int_clamped);
				endcase
			end

			// Advance the program
			if (in_acc) begin
				busy_q <= 1'b1;
				pc_q   <= carpm_pkg::STEP_ANG_ERR;
				axis_q <= carpm_pkg::AXIS_ROLL;
			end else if (busy_q) begin
				case (uc.jmp)
					carpm_pkg::JMP_AXIS: begin
						if (axis_q == carpm_pkg::AXIS_LAST) begin
							axis_q <= carpm_pkg::AXIS_ROLL;
							pc_q   <= pc_q + 1'b1;
						end else begin
							axis_q <= axis_q + 1'b1;
							pc_q   <= uc.target;
						end
					end
					carpm_pkg::JMP_DONE: begin
						if (done_go) begin
							busy_q <= 1'b0;
							pc_q   <= carpm_pkg::STEP_ANG_ERR;
						end
					end
					default: pc_q <= pc_q + 1'b1;
				endcase
			end

			// Output word valid
			if (done_go)
				m_tvalid_q <= 1'b1;
			else if (m_axis_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_acc)
			in_q <= s_axis_tdata;

		if (busy_q) begin
			case (uc.e_op)
				carpm_pkg::E_ANGLE: e_q <= 18'(tgt_sel) - 18'(ang_sel);
				carpm_pkg::E_RATE:  e_q <= 18'(c_q) - 18'(rate_sel);
				default: ;
			endcase

			if (uc.mul != carpm_pkg::MUL_NONE)
				p_q <= mul_prod;

			// Integral term enters shifted down with its sign kept
			case (uc.acc)
				carpm_pkg::ACC_INT_ADD: acc_q <= 36'(int_rd) + p_q[35:0];
				carpm_pkg::ACC_LOAD_P:  acc_q <= p_q[35:0];
				carpm_pkg::ACC_ADD_PSH: acc_q <= acc_q + 36'(signed'(p_q[48:16]));
				default: ;
			endcase

			case (uc.fin)
				carpm_pkg::FIN_CMD: c_q <= cmd_next;
				carpm_pkg::FIN_CORR: begin
					case (axis_q)
						carpm_pkg::AXIS_ROLL:  corr_q[0] <= corr_next;
						carpm_pkg::AXIS_PITCH: corr_q[1] <= corr_next;
						default:               corr_q[2] <= corr_next;
					endcase
				end
				default: ;
			endcase
		end

		// Load the output word
		if (done_go) begin
			m_data_q <= mix_data;
			m_user_q <= mix_idle;
		end
	end

	assign m_axis_tvalid   = m_tvalid_q;
	assign m_axis_tdata    = m_data_q;
	assign m_axis_tuser[0] = m_user_q;

	// Register read back
	always_comb begin
		case (paddr[5:3])
			carpm_pkg::REG_OUTER_P:    prdata = {16'd0, outer_p_q};
			carpm_pkg::REG_OUTER_I:    prdata = {16'd0, outer_i_q};
			carpm_pkg::REG_INNER_P:    prdata = {16'd0, inner_p_q};
			carpm_pkg::REG_INNER_I:    prdata = {16'd0, inner_i_q};
			carpm_pkg::REG_TARGET:     prdata = {16'd0, target_q};
			carpm_pkg::REG_ANG_LIMIT:  prdata = {49'd0, ang_lim_q};
			carpm_pkg::REG_RATE_LIMIT: prdata = {49'd0, rate_lim_q};
			default:                   prdata = {32'd0, out_lim_q};
		endcase
	end

	// An accepted word starts the program at the first step of the roll axis
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> busy_q && pc_q == carpm_pkg::STEP_ANG_ERR &&
			axis_q == carpm_pkg::AXIS_ROLL)
		else $error("program did not start at the first step");

	// The axis loop leaves for the mixing step only after yaw
	a_axis_exit: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q && uc.jmp == carpm_pkg::JMP_AXIS && axis_q == carpm_pkg::AXIS_LAST |=>
			pc_q == carpm_pkg::STEP_DONE && axis_q == carpm_pkg::AXIS_ROLL)
		else $error("axis loop exit went wrong");

	// A result appears only from the mixing step
	a_out_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(busy_q && pc_q == carpm_pkg::STEP_DONE))
		else $error("output word raised outside the mixing step");

	// Idle words carry the idle motor value on all four motors
	a_idle_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			m_axis_tdata == {4{carpm_pkg::IDLE_MOTOR}})
		else $error("idle word with non-idle motor values");

endmodule
